[hw/rtl/rcpa_pkg.sv]
// rcpa_pkg: shared constants, codes and types of the page allocator
// used by every module under hw/rtl except rcpa_ram; depends on nothing
`timescale 1ns / 1ps

package rcpa_pkg;

  localparam int NumPages  = 4096;
  localparam int PageBytes = 4096;
  localparam int CountBits = 8;
  localparam int AddrBits  = 24;

  localparam int PageBits = $clog2(NumPages);
  localparam int OffsBits = $clog2(PageBytes);
  localparam int TopBits  = PageBits + 1;

  localparam int CfgBits     = 12;
  localparam int ApbAddrBits = 3;
  localparam int ApbDataBits = 32;

  localparam logic [CountBits-1:0] CountMax = '1;
  localparam logic [CountBits-1:0] CountOne = CountBits'(1);

  // register index decoded from paddr[2]
  localparam logic RegFirstPage = 1'b0;
  localparam logic [CfgBits-1:0] FirstPageReset = CfgBits'(1);

  typedef enum logic [1:0] {
    OpAlloc  = 2'd0,
    OpFree   = 2'd1,
    OpAddRef = 2'd2,
    OpCopy   = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StOom       = 3'd1,
    StBadAddr   = 3'd2,
    StUnderflow = 3'd3,
    StSaturated = 3'd4
  } status_e;

  typedef enum logic [1:0] {
    StateClear,
    StateIdle,
    StateExec,
    StateFix
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic clear;
    logic accept;
    logic exec;
    logic fix;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic clear_last;
    logic need_fix;
  } stat_t;

  function automatic logic [AddrBits-1:0] page_to_addr(logic [PageBits-1:0] page);
    logic [PageBits+OffsBits-1:0] full;
    full = {page, {OffsBits{1'b0}}};
    return AddrBits'(full);
  endfunction

endpackage

[hw/rtl/refcounted_page_allocator.sv]
// refcounted_page_allocator: top level, apb register and controller/datapath wiring
// depends on rcpa_pkg, rcpa_ctrl, rcpa_datapath
`timescale 1ns / 1ps

// page allocator with a lifo free stack and per-page reference counts
// command channel: drive op_i and page_address_i with start high; the item is
//   taken at the clock edge where start is high and busy is low
// ops: allocate pops a page (count set to one), free drops a reference and
//   pushes the page at zero, add reference bumps the count (saturating),
//   copy if shared hands out a fresh page when the count is above one
// result channel: result_valid_o is high for exactly one cycle with
//   result_address_o, new_page_o and status_o; the receiver cannot stall it
// result: the execute state, entered at the accepting edge, loads the result
//   registers; the count memory has a single write port, read in the accept
//   cycle and written in the execute cycle (and again for the old page on a
//   fresh copy); no new item is taken before the last is through: the block
//   returns to idle once the execute cycle, or on a fresh copy the fix-up, ends
// the next item may be started in the same cycle its predecessor's result is
//   shown, except after a fresh copy, where the fix-up cycle comes first
// reset: every count returns to one via a clearing pass over all 4096 pages,
//   busy stays high meanwhile; the free stack starts empty, so software
//   frees each usable page to fill it
// apb: register first_usable_page at byte address 0, written in the access
//   phase, taken at any time; pready is tied high

module refcounted_page_allocator (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // command channel
  input  logic                                start,
  output logic                                busy,
  input  logic [1:0]                          op_i,
  input  logic [rcpa_pkg::AddrBits-1:0]       page_address_i,
  // result channel
  output logic                                result_valid_o,
  output logic [rcpa_pkg::AddrBits-1:0]       result_address_o,
  output logic                                new_page_o,
  output logic [2:0]                          status_o,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [rcpa_pkg::ApbAddrBits-1:0]    paddr,
  input  logic [rcpa_pkg::ApbDataBits-1:0]    pwdata,
  output logic [rcpa_pkg::ApbDataBits-1:0]    prdata,
  output logic                                pready
);

  // first usable page register
  logic [rcpa_pkg::CfgBits-1:0] first_page_q;
  logic                         reg_sel;
  logic                         reg_wr;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2] == rcpa_pkg::RegFirstPage;
  assign reg_wr  = psel & penable & pwrite & pready & reg_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      first_page_q <= rcpa_pkg::FirstPageReset;
    end else if (reg_wr) begin
      first_page_q <= pwdata[rcpa_pkg::CfgBits-1:0];
    end
  end

  // unmapped addresses read as zero
  assign prdata = reg_sel ? rcpa_pkg::ApbDataBits'(first_page_q) : '0;

  // controller and datapath
  rcpa_pkg::cmd_t  cmd;
  rcpa_pkg::stat_t stat;

  rcpa_ctrl u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  rcpa_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .stat_o           (stat),
    .op_i             (op_i),
    .page_address_i   (page_address_i),
    .first_page_i     (first_page_q),
    .result_valid_o   (result_valid_o),
    .result_address_o (result_address_o),
    .new_page_o       (new_page_o),
    .status_o         (status_o)
  );

endmodule

[hw/rtl/rcpa_ram.sv]
// rcpa_ram: generic single-write, single-read ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module rcpa_ram #(
  parameter int Width = 8,
  parameter int Depth = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/rcpa_ctrl.sv]
// rcpa_ctrl: sequencer of the page allocator (clear pass, accept, execute, fix-up)
// depends on rcpa_pkg
`timescale 1ns / 1ps

module rcpa_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  rcpa_pkg::stat_t stat_i,
  output rcpa_pkg::cmd_t  cmd_o,
  output logic           busy_o
);

  rcpa_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= rcpa_pkg::StateClear;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      rcpa_pkg::StateClear: begin
        if (stat_i.clear_last) state_d = rcpa_pkg::StateIdle;
      end
      rcpa_pkg::StateIdle: begin
        if (start_i) state_d = rcpa_pkg::StateExec;
      end
      rcpa_pkg::StateExec: begin
        state_d = stat_i.need_fix ? rcpa_pkg::StateFix : rcpa_pkg::StateIdle;
      end
      rcpa_pkg::StateFix: begin
        state_d = rcpa_pkg::StateIdle;
      end
      default: begin
        state_d = rcpa_pkg::StateIdle;
      end
    endcase
  end

  always_comb begin
    cmd_o  = '0;
    busy_o = 1'b1;
    case (state_q)
      rcpa_pkg::StateClear: cmd_o.clear = 1'b1;
      rcpa_pkg::StateIdle: begin
        busy_o       = 1'b0;
        cmd_o.accept = start_i;
      end
      rcpa_pkg::StateExec: cmd_o.exec = 1'b1;
      rcpa_pkg::StateFix:  cmd_o.fix  = 1'b1;
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

endmodule

[hw/rtl/rcpa_datapath.sv]
// rcpa_datapath: free stack, reference count memory, stack pointer and result registers
// depends on rcpa_pkg and rcpa_ram
`timescale 1ns / 1ps

module rcpa_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rcpa_pkg::cmd_t                    cmd_i,
  output rcpa_pkg::stat_t                   stat_o,
  input  logic [1:0]                        op_i,
  input  logic [rcpa_pkg::AddrBits-1:0]     page_address_i,
  input  logic [rcpa_pkg::CfgBits-1:0]      first_page_i,
  output logic                              result_valid_o,
  output logic [rcpa_pkg::AddrBits-1:0]     result_address_o,
  output logic                              new_page_o,
  output logic [2:0]                        status_o
);

  localparam int PB = rcpa_pkg::PageBits;
  localparam int CB = rcpa_pkg::CountBits;
  localparam int AB = rcpa_pkg::AddrBits;
  localparam int TB = rcpa_pkg::TopBits;

  // latched item
  logic [1:0]    op_q;
  logic [AB-1:0] addr_q;
  logic [TB-1:0] top_q, top_d;
  logic [PB-1:0] clr_q;

  logic [AB-1:0]   res_addr_q, res_addr_d;
  logic            fresh_q, fresh_d;
  rcpa_pkg::status_e status_q, status_d;
  logic            valid_q;

  // page of the incoming address, for the count read at accept
  logic [AB-1:0] in_page_full;
  logic [PB-1:0] in_page;
  assign in_page_full = page_address_i >> rcpa_pkg::OffsBits;
  assign in_page = (in_page_full < AB'(rcpa_pkg::NumPages)) ? in_page_full[PB-1:0] : '0;

  // page of the latched address
  logic [AB-1:0] page_full;
  logic          in_range, aligned, below_first;
  logic [PB-1:0] page;
  assign page_full   = addr_q >> rcpa_pkg::OffsBits;
  assign in_range    = page_full < AB'(rcpa_pkg::NumPages);
  assign page        = in_range ? page_full[PB-1:0] : '0;
  assign aligned     = addr_q[rcpa_pkg::OffsBits-1:0] == '0;
  assign below_first = {{(TB-PB){1'b0}}, page} < TB'(first_page_i);

  // memories
  logic          cnt_we;
  logic [PB-1:0] cnt_waddr;
  logic [CB-1:0] cnt_wdata, cnt;
  logic          stk_we;
  logic [PB-1:0] stk_raddr;
  logic [PB-1:0] stk_rdata;
  logic [TB-1:0] top_m1;

  assign top_m1    = top_q - TB'(1);
  assign stk_raddr = top_m1[PB-1:0];

  rcpa_ram #(.Width(CB), .Depth(rcpa_pkg::NumPages)) u_count_ram (
    .clk_i   (clk_i),
    .we_i    (cnt_we),
    .waddr_i (cnt_waddr),
    .wdata_i (cnt_wdata),
    .re_i    (cmd_i.accept),
    .raddr_i (in_page),
    .rdata_o (cnt)
  );

  rcpa_ram #(.Width(PB), .Depth(rcpa_pkg::NumPages)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (top_q[PB-1:0]),
    .wdata_i (page),
    .re_i    (cmd_i.accept),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  // popped page, forced to zero when out of range
  logic [PB-1:0] np;
  logic          stack_empty, stack_full;
  assign np          = ({1'b0, stk_rdata} < TB'(rcpa_pkg::NumPages)) ? stk_rdata : '0;
  assign stack_empty = top_q == '0;
  assign stack_full  = top_q >= TB'(rcpa_pkg::NumPages);

  // decisions of the execute cycle
  logic          e_cnt_we, e_stk_we, e_need_fix;
  logic [PB-1:0] e_cnt_waddr;
  logic [CB-1:0] e_cnt_wdata;
  logic [TB-1:0] e_top;

  always_comb begin
    e_cnt_we    = 1'b0;
    e_cnt_waddr = page;
    e_cnt_wdata = cnt;
    e_stk_we    = 1'b0;
    e_need_fix  = 1'b0;
    e_top       = top_q;
    res_addr_d  = addr_q;
    fresh_d     = 1'b0;
    status_d    = rcpa_pkg::StOk;
    case (rcpa_pkg::op_e'(op_q))
      rcpa_pkg::OpAlloc: begin
        if (stack_empty || (top_q > TB'(rcpa_pkg::NumPages))) begin
          res_addr_d = '0;
          status_d   = rcpa_pkg::StOom;
        end else begin
          e_top       = top_m1;
          e_cnt_we    = 1'b1;
          e_cnt_waddr = np;
          e_cnt_wdata = rcpa_pkg::CountOne;
          res_addr_d  = rcpa_pkg::page_to_addr(np);
        end
      end
      rcpa_pkg::OpFree: begin
        if (!aligned || !in_range || below_first) begin
          status_d = rcpa_pkg::StBadAddr;
        end else if (cnt == '0) begin
          status_d = rcpa_pkg::StUnderflow;
        end else begin
          e_cnt_we    = 1'b1;
          e_cnt_wdata = cnt - CB'(1);
          if ((cnt == rcpa_pkg::CountOne) && !stack_full) begin
            e_stk_we = 1'b1;
            e_top    = top_q + TB'(1);
          end
        end
      end
      rcpa_pkg::OpAddRef: begin
        if (!in_range) begin
          status_d = rcpa_pkg::StBadAddr;
        end else if (cnt == rcpa_pkg::CountMax) begin
          status_d = rcpa_pkg::StSaturated;
        end else begin
          e_cnt_we    = 1'b1;
          e_cnt_wdata = cnt + CB'(1);
        end
      end
      rcpa_pkg::OpCopy: begin
        if (!in_range) begin
          status_d = rcpa_pkg::StBadAddr;
        end else if (cnt > rcpa_pkg::CountOne) begin
          if (stack_empty || (top_q > TB'(rcpa_pkg::NumPages))) begin
            res_addr_d = '0;
            status_d   = rcpa_pkg::StOom;
          end else begin
            // new page gets count one now, old page drops in the fix-up cycle
            e_top       = top_m1;
            e_cnt_we    = 1'b1;
            e_cnt_waddr = np;
            e_cnt_wdata = rcpa_pkg::CountOne;
            e_need_fix  = 1'b1;
            res_addr_d  = rcpa_pkg::page_to_addr(np);
            fresh_d     = 1'b1;
          end
        end
      end
      default: begin
        status_d = rcpa_pkg::StOk;
      end
    endcase
  end

  // count memory write port: clear pass, fix-up, execute
  always_comb begin
    cnt_we    = 1'b0;
    cnt_waddr = page;
    cnt_wdata = cnt;
    if (cmd_i.clear) begin
      cnt_we    = 1'b1;
      cnt_waddr = clr_q;
      cnt_wdata = rcpa_pkg::CountOne;
    end else if (cmd_i.fix) begin
      // same page popped: it was just set to one, so it ends at zero
      cnt_we    = 1'b1;
      cnt_waddr = page;
      cnt_wdata = (np == page) ? '0 : cnt - CB'(1);
    end else if (cmd_i.exec) begin
      cnt_we    = e_cnt_we;
      cnt_waddr = e_cnt_waddr;
      cnt_wdata = e_cnt_wdata;
    end
  end

  assign stk_we = cmd_i.exec & e_stk_we;
  assign top_d  = cmd_i.exec ? e_top : top_q;

  assign stat_o.clear_last = clr_q == PB'(rcpa_pkg::NumPages - 1);
  assign stat_o.need_fix   = e_need_fix;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q   <= '0;
      clr_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      top_q   <= top_d;
      valid_q <= cmd_i.exec;
      if (cmd_i.clear) clr_q <= clr_q + PB'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      op_q   <= op_i;
      addr_q <= page_address_i;
    end
    if (cmd_i.exec) begin
      res_addr_q <= res_addr_d;
      fresh_q    <= fresh_d;
      status_q   <= status_d;
    end
  end

  assign result_valid_o   = valid_q;
  assign result_address_o = res_addr_q;
  assign new_page_o       = fresh_q;
  assign status_o         = status_q;

endmodule

[hw/rtl/rcpa_checker.sv]
// rcpa_checker: port-level assertions of the page allocator, bound to the top level
// depends on rcpa_pkg and refcounted_page_allocator
`timescale 1ns / 1ps

module rcpa_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              start,
  input logic                              busy,
  input logic                              result_valid_o,
  input logic [rcpa_pkg::AddrBits-1:0]     result_address_o,
  input logic                              new_page_o,
  input logic [2:0]                        status_o
);

  // an accepted item keeps the block busy in the next cycle
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("block not busy after accepting an item");

  // results never come in adjacent cycles
  a_strobe_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |=> !result_valid_o)
    else $error("result strobe held for two cycles");

  // a result follows an execute cycle, in which the block is busy
  a_strobe_after_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(busy))
    else $error("result without a preceding busy cycle");

  // out of memory always reports a null address and no fresh page
  a_oom_null: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && (status_o == rcpa_pkg::StOom))
      |-> ((result_address_o == '0) && !new_page_o))
    else $error("out of memory with a non-null result");

  // a fresh page is only handed out with ok status
  a_fresh_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && new_page_o) |-> (status_o == rcpa_pkg::StOk))
    else $error("fresh page with error status");

endmodule

bind refcounted_page_allocator rcpa_checker u_rcpa_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .start            (start),
  .busy             (busy),
  .result_valid_o   (result_valid_o),
  .result_address_o (result_address_o),
  .new_page_o       (new_page_o),
  .status_o         (status_o)
);

[test/refcounted_page_allocator_tb.sv]
// refcounted_page_allocator_tb: self-checking bench for the page allocator, holding its own
// allocator prediction in a scoreboard class; depends on rcpa_pkg and refcounted_page_allocator
`timescale 1ns / 1ps

module refcounted_page_allocator_tb;
  import rcpa_pkg::*;

  localparam int ClockHalf  = 6;
  localparam int StallLimit = 20000;   // covers the clearing pass over all 4096 pages after reset

  // one expected result item
  typedef struct {
    logic [AddrBits-1:0] address;
    logic                fresh;
    status_e             status;
  } page_result_t;

  // tracks free pages and reference counts, and queues the result each item should give
  class page_alloc_tracker;
    logic [PageBits-1:0]  free_pages [NumPages];
    logic [TopBits-1:0]   depth;
    logic [CountBits-1:0] refs [NumPages];
    logic [CfgBits-1:0]   first_page;
    page_result_t         awaited [$];
    int                   errors;

    function new();
      depth      = '0;
      first_page = FirstPageReset;
      errors     = 0;
      foreach (refs[i]) refs[i] = CountOne;
      foreach (free_pages[i]) free_pages[i] = '0;
    endfunction

    function void set_first_page(logic [CfgBits-1:0] value);
      first_page = value;
    endfunction

    function int pending_count();
      return awaited.size();
    endfunction

    // pop the most recently freed page, its count restarts at one
    function bit take_page(output logic [PageBits-1:0] pg);
      if (depth == '0) return 1'b0;
      depth--;
      pg = free_pages[depth[PageBits-1:0]];
      refs[pg] = CountOne;
      return 1'b1;
    endfunction

    function void note_command(op_e op, logic [AddrBits-1:0] address);
      logic [PageBits-1:0] pg;
      logic [PageBits-1:0] fresh_pg;
      page_result_t        r;
      // every 24-bit address maps onto one of the pages, so no range check here
      pg        = PageBits'(address >> OffsBits);
      r.address = address;
      r.fresh   = 1'b0;
      r.status  = StOk;
      case (op)
        OpAlloc: begin
          if (take_page(fresh_pg)) begin
            r.address = AddrBits'(fresh_pg) << OffsBits;
          end else begin
            r.address = '0;
            r.status  = StOom;
          end
        end
        OpFree: begin
          if (address[OffsBits-1:0] != '0 || pg < first_page) begin
            r.status = StBadAddr;
          end else if (refs[pg] == '0) begin
            r.status = StUnderflow;
          end else begin
            refs[pg]--;
            // with the stack full the count still drops but the push is lost
            if (refs[pg] == '0 && depth < NumPages) begin
              free_pages[depth[PageBits-1:0]] = pg;
              depth++;
            end
          end
        end
        OpAddRef: begin
          if (refs[pg] == CountMax) r.status = StSaturated;
          else refs[pg]++;
        end
        OpCopy: begin
          if (refs[pg] > CountOne) begin
            // new page count is set first, then the old one drops (they may be the same page)
            if (take_page(fresh_pg)) begin
              if (refs[pg] != '0) refs[pg]--;
              r.address = AddrBits'(fresh_pg) << OffsBits;
              r.fresh   = 1'b1;
            end else begin
              r.address = '0;
              r.status  = StOom;
            end
          end
        end
        default: begin
          r.status = StOk;
        end
      endcase
      awaited.push_back(r);
    endfunction

    function void check_result(logic [AddrBits-1:0] address, logic fresh, logic [2:0] status);
      page_result_t want;
      if (awaited.size() == 0) begin
        errors++;
        $display("%0t: result with none awaited: address %h new_page %b status %0d",
                 $time, address, fresh, status);
        return;
      end
      want = awaited.pop_front();
      if (address !== want.address) begin
        errors++;
        $display("%0t: result_address expected %h actual %h", $time, want.address, address);
      end
      if (fresh !== want.fresh) begin
        errors++;
        $display("%0t: new_page expected %b actual %b", $time, want.fresh, fresh);
      end
      if (status !== 3'(want.status)) begin
        errors++;
        $display("%0t: status expected %0d actual %0d", $time, want.status, status);
      end
    endfunction
  endclass

  logic                   clk_i = 1'b0;
  logic                   rst_ni;
  logic                   start;
  logic                   busy;
  logic [1:0]             op_i;
  logic [AddrBits-1:0]    page_address_i;
  logic                   result_valid_o;
  logic [AddrBits-1:0]    result_address_o;
  logic                   new_page_o;
  logic [2:0]             status_o;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [ApbAddrBits-1:0] paddr;
  logic [ApbDataBits-1:0] pwdata;
  logic [ApbDataBits-1:0] prdata;
  logic                   pready;

  page_alloc_tracker tracker;

  always #ClockHalf clk_i = ~clk_i;

  refcounted_page_allocator dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .op_i             (op_i),
    .page_address_i   (page_address_i),
    .result_valid_o   (result_valid_o),
    .result_address_o (result_address_o),
    .new_page_o       (new_page_o),
    .status_o         (status_o),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready)
  );

  // result items are sampled at the edge that ends their strobe cycle
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o === 1'b1) begin
      tracker.check_result(result_address_o, new_page_o, status_o);
    end
  end

  // watchdog: ends the run once nothing has moved for too long
  initial begin : watchdog
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < StallLimit) begin
      @(posedge clk_i);
      if ((start && !busy) || result_valid_o === 1'b1 || (psel && penable)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("simulation failed");
    $finish;
  end

  // drive one item from a falling edge, hold it until taken, return at the next falling edge
  // start stays high so back-to-back items need no extra edge
  task automatic run_command(op_e op, logic [AddrBits-1:0] address);
    start          <= 1'b1;
    op_i           <= op;
    page_address_i <= address;
    do @(posedge clk_i); while (busy !== 1'b0);
    tracker.note_command(op, address);
    @(negedge clk_i);
  endtask

  // random sender gap, mostly short, now and then longer than an operation
  task automatic sender_pause(int unsigned pct);
    if ($urandom_range(99) < pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(9) == 0) ? 12 : 3)) @(negedge clk_i);
    end
  endtask

  // stop sending and wait for every outstanding result item
  task automatic drain_results();
    start <= 1'b0;
    while (tracker.pending_count() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // apb write: setup cycle, then access cycle until pready
  task automatic write_first_page(logic [CfgBits-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {RegFirstPage, 2'b00};
    pwdata  <= ApbDataBits'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    tracker.set_first_page(value);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // mixed traffic around a few hot pages, with fully random addresses and allocate bursts
  task automatic random_traffic(int unsigned n_items, int unsigned idle_pct);
    int unsigned         sent;
    int unsigned         roll;
    int unsigned         burst;
    op_e                 op;
    logic [PageBits-1:0] pg;
    logic [AddrBits-1:0] address;
    sent = 0;
    while (sent < n_items) begin
      roll = $urandom_range(99);
      if (roll < 5) begin
        // allocate burst to run the free stack dry now and then
        burst = $urandom_range(2, 12);
        repeat (burst) begin
          run_command(OpAlloc, AddrBits'($urandom));
          sender_pause(idle_pct);
        end
        sent += burst;
      end else begin
        if (roll < 25) op = OpAlloc;
        else if (roll < 60) op = OpFree;
        else if (roll < 80) op = OpAddRef;
        else op = OpCopy;
        roll = $urandom_range(99);
        if (roll < 15) begin
          address = AddrBits'($urandom);
        end else begin
          if (roll < 70) pg = PageBits'($urandom_range(0, 47));
          else if (roll < 80) pg = PageBits'(NumPages - 1 - $urandom_range(0, 15));
          else pg = PageBits'($urandom);
          address = AddrBits'(pg) << OffsBits;
        end
        run_command(op, address);
        sender_pause(idle_pct);
        sent++;
      end
    end
  endtask

  initial begin
    int unsigned         phase;
    int unsigned         idle_pct;
    logic [CfgBits-1:0]  first_value;

    tracker        = new();
    rst_ni         = 1'b0;
    start          = 1'b0;
    op_i           = OpAlloc;
    page_address_i = '0;
    psel           = 1'b0;
    penable        = 1'b0;
    pwrite         = 1'b0;
    paddr          = '0;
    pwdata         = '0;
    repeat (4) @(negedge clk_i);
    rst_ni <= 1'b1;

    // register is taken at any time, the clearing pass holds busy meanwhile
    write_first_page(CfgBits'(1));

    // directed: empty stack, bad addresses, underflow, copies with and without a fresh page
    run_command(OpAlloc, 24'h000000);   // nothing free yet
    run_command(OpCopy, 24'h005000);    // count one, unchanged
    run_command(OpFree, 24'h001001);    // misaligned
    run_command(OpFree, 24'h000000);    // below the first usable page
    run_command(OpFree, 24'hFFF000);    // top page pushed
    run_command(OpFree, 24'hFFF000);    // count already zero
    run_command(OpAddRef, 24'hFFFFFF);  // add reference skips the alignment check
    run_command(OpFree, 24'h001000);
    run_command(OpAlloc, 24'hFFFFFF);
    run_command(OpAddRef, 24'h001000);
    run_command(OpCopy, 24'h001000);    // shared, takes a fresh page
    run_command(OpCopy, 24'h001000);    // no longer shared
    run_command(OpAddRef, 24'h001000);
    run_command(OpCopy, 24'h001ABC);    // shared but the stack is empty
    run_command(OpAlloc, 24'hFFFFFF);
    run_command(OpFree, 24'hFFF000);
    run_command(OpAddRef, 24'hFFF000);  // page sits on the stack with a nonzero count
    run_command(OpAddRef, 24'hFFF000);
    run_command(OpCopy, 24'hFFF000);    // pops the very page being copied
    run_command(OpFree, 24'hFFF001);
    run_command(OpFree, 24'h7FF000);
    run_command(OpAlloc, 24'h123456);

    // count saturation, then copies of a saturated page
    repeat (256) run_command(OpAddRef, 24'h002000);
    run_command(OpCopy, 24'h002000);
    run_command(OpFree, 24'h003000);
    run_command(OpCopy, 24'h002000);
    run_command(OpFree, 24'h002000);

    // random phases, each with its own lower bound and sender idling
    for (phase = 0; phase < 8; phase++) begin
      drain_results();
      case (phase % 4)
        0: first_value = CfgBits'(1);
        1: first_value = CfgBits'($urandom_range(2, 48));
        2: first_value = CfgBits'($urandom_range(1, 4095));
        default: first_value = (phase == 3) ? CfgBits'(4095) : CfgBits'($urandom_range(2, 48));
      endcase
      case (phase % 4)
        1: idle_pct = 74;
        3: idle_pct = 22;
        default: idle_pct = 0;
      endcase
      write_first_page(first_value);
      random_traffic(100, idle_pct);
    end

    // last short phase back at the default lower bound
    drain_results();
    write_first_page(CfgBits'(1));
    random_traffic(40, 22);

    drain_results();
    repeat (8) @(posedge clk_i);
    if (tracker.errors == 0 && tracker.pending_count() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
